// ----- rtl/lef_pkg.sv -----
// ----------------------------------------------------------------------------
// lef_pkg: shared types and constants of the 3x3 Laplacian edge filter
// Field widths, register codes, kernel codes and the window kernel sum.
// ----------------------------------------------------------------------------
`default_nettype none

package lef_pkg;

	// field and register widths
	localparam int unsigned LEF_PIX_W      = 8;
	localparam int unsigned LEF_ROW_W      = 12;
	localparam int unsigned LEF_GAIN_W     = 16;
	localparam int unsigned LEF_KSEL_W     = 2;
	localparam int unsigned LEF_IMG_W_W    = 11;
	localparam int unsigned LEF_IMG_H_W    = 13;
	localparam int unsigned LEF_CFG_IDX_W  = 2;
	localparam int unsigned LEF_CFG_DATA_W = 16;

	// dimension compare width: holds 4096, the largest legal width or height
	localparam int unsigned LEF_DIM_W      = 13;
	localparam int unsigned LEF_MIN_DIM    = 3;
	localparam int unsigned LEF_MAX_HEIGHT = 4096;
	localparam int unsigned LEF_FIRST_IN   = 2;

	localparam int unsigned LEF_MAX_WIDTH  = 1024;

	// arithmetic widths: |sum| <= 2040
	localparam int unsigned LEF_SUM_W  = 12;
	localparam int unsigned LEF_ACC_W  = 13;
	localparam int unsigned LEF_PROD_W = LEF_SUM_W + LEF_GAIN_W;
	localparam int unsigned LEF_FRAC_W = 8;
	localparam int unsigned LEF_SAT_MAX = 255;

	// reset values of the registers
	localparam logic [LEF_KSEL_W-1:0]  LEF_KSEL_RST  = LEF_KSEL_W'(0);
	localparam logic [LEF_GAIN_W-1:0]  LEF_GAIN_RST  = LEF_GAIN_W'(512);
	localparam logic [LEF_IMG_W_W-1:0] LEF_WIDTH_RST = LEF_IMG_W_W'(256);
	localparam logic [LEF_IMG_H_W-1:0] LEF_HEIGHT_RST = LEF_IMG_H_W'(256);

	localparam int unsigned LEF_Q_DEPTH = 4;

	typedef enum logic [LEF_CFG_IDX_W-1:0] {
		LEF_REG_KERNEL = 2'd0,
		LEF_REG_GAIN   = 2'd1,
		LEF_REG_WIDTH  = 2'd2,
		LEF_REG_HEIGHT = 2'd3
	} lef_reg_t;

	typedef enum logic [LEF_KSEL_W-1:0] {
		LEF_K_FOUR  = 2'd0,
		LEF_K_EIGHT = 2'd1,
		LEF_K_DIAG  = 2'd2
	} lef_kernel_t;

	// 3x3 window, index 3*row + col, row 0 on top, col 2 newest
	typedef logic [8:0][LEF_PIX_W-1:0] lef_win_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} lef_q_stat_t;

	// Signed kernel response of one window. Unused select acts as four-neighbour.
	function automatic logic signed [LEF_SUM_W-1:0] lef_kernel_sum(
		input lef_win_t win,
		input logic [LEF_KSEL_W-1:0] sel
	);
		logic signed [LEF_ACC_W-1:0] center;
		logic signed [LEF_ACC_W-1:0] edges;
		logic signed [LEF_ACC_W-1:0] corners;
		logic signed [LEF_ACC_W-1:0] acc;
		center  = LEF_ACC_W'(win[4]);
		edges   = LEF_ACC_W'(win[1]) + LEF_ACC_W'(win[3])
			+ LEF_ACC_W'(win[5]) + LEF_ACC_W'(win[7]);
		corners = LEF_ACC_W'(win[0]) + LEF_ACC_W'(win[2])
			+ LEF_ACC_W'(win[6]) + LEF_ACC_W'(win[8]);
		case (sel)
			LEF_K_EIGHT: acc = (center <<< 3) - edges - corners;
			LEF_K_DIAG:  acc = (center <<< 2) - (edges <<< 1) + corners;
			default:     acc = (center <<< 2) - edges;
		endcase
		return LEF_SUM_W'(acc);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lef_ifs.sv -----
// ----------------------------------------------------------------------------
// lef_ifs: channel interfaces of the edge filter
// Pixel input stream, result stream and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lef_pix_if import lef_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [LEF_PIX_W-1:0] pixel_in;

	modport source(output valid, output pixel_in, input ready);
	modport sink(input valid, input pixel_in, output ready);
endinterface

interface lef_res_if import lef_pkg::*; #(
	parameter int unsigned COL_W = $clog2(LEF_MAX_WIDTH)
);
	logic                 valid;
	logic                 ready;
	logic [LEF_PIX_W-1:0] edge_value;
	logic [COL_W-1:0]     out_column;
	logic [LEF_ROW_W-1:0] out_row;
	logic                 frame_last;

	modport source(output valid, output edge_value, output out_column,
		output out_row, output frame_last, input ready);
	modport sink(input valid, input edge_value, input out_column,
		input out_row, input frame_last, output ready);
endinterface

interface lef_cfg_if import lef_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [LEF_CFG_IDX_W-1:0]  index;
	logic [LEF_CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/lef_queue.sv -----
// ----------------------------------------------------------------------------
// lef_queue: small register FIFO between the window front and the scaler
// Holds classified kernel sums until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_queue import lef_pkg::*; #(
	parameter int unsigned DATA_W = LEF_SUM_W + $clog2(LEF_MAX_WIDTH) + LEF_ROW_W + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	input  wire logic              pop,
	output lef_q_stat_t            stat,
	output logic      [DATA_W-1:0] pop_data
);

	localparam int unsigned PTR_W = $clog2(LEF_Q_DEPTH);
	localparam int unsigned CNT_W = $clog2(LEF_Q_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [LEF_Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign stat.nonempty = (count_q != '0);
	assign stat.full     = (count_q == CNT_W'(LEF_Q_DEPTH));
	assign pop_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/lef_front.sv -----
// ----------------------------------------------------------------------------
// lef_front: raster counters, line store, 3x3 window and kernel sum
// Takes one pixel per cycle unless a kernel sum waits on a full queue, keeps
// the neighbourhood and queues the signed kernel response of every interior
// pixel with its coordinates.
`default_nettype none

module lef_front import lef_pkg::*; #(
	parameter int unsigned MAX_WIDTH = LEF_MAX_WIDTH,
	parameter int unsigned COL_W     = $clog2(MAX_WIDTH),
	parameter int unsigned DATA_W    = LEF_SUM_W + COL_W + LEF_ROW_W + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	lef_pix_if.sink                     pix,
	input  wire logic [LEF_KSEL_W-1:0]  kernel_select,
	input  wire logic [LEF_IMG_W_W-1:0] image_width,
	input  wire logic [LEF_IMG_H_W-1:0] image_height,
	input  wire lef_q_stat_t            q_stat,
	output logic                        q_push,
	output logic [DATA_W-1:0]           q_data
);

	localparam int unsigned MEM_W = 2 * LEF_PIX_W;

	logic [LEF_DIM_W-1:0] w_eff;
	logic [LEF_DIM_W-1:0] h_eff;
	logic [LEF_DIM_W-1:0] c_ext;
	logic [LEF_DIM_W-1:0] r_ext;
	logic [LEF_DIM_W-1:0] c_inc;
	logic [LEF_DIM_W-1:0] r_inc;
	logic [COL_W-1:0]     col_q;
	logic [LEF_ROW_W-1:0] row_q;
	logic [COL_W-1:0]     col_n;
	logic [LEF_ROW_W-1:0] row_n;
	logic                 emit;
	logic                 last;
	logic                 adv;
	logic                 accept;

	// line store word: upper byte previous row, lower byte the row before
	logic [MEM_W-1:0]     line_mem [MAX_WIDTH];
	logic [MEM_W-1:0]     rd_q;

	logic                 valid_s1;
	logic [LEF_PIX_W-1:0] pix_s1;
	logic [COL_W-1:0]     addr_s1;
	logic                 emit_s1;
	logic [COL_W-1:0]     col_s1;
	logic [LEF_ROW_W-1:0] row_s1;
	logic                 last_s1;

	logic                 valid_s2;
	logic [COL_W-1:0]     col_s2;
	logic [LEF_ROW_W-1:0] row_s2;
	logic                 last_s2;

	lef_win_t             win_q;
	logic signed [LEF_SUM_W-1:0] sum;

	// effective frame size
	always_comb begin
		if (LEF_DIM_W'(image_width) < LEF_DIM_W'(LEF_MIN_DIM)) begin
			w_eff = LEF_DIM_W'(LEF_MIN_DIM);
		end else if (LEF_DIM_W'(image_width) > LEF_DIM_W'(MAX_WIDTH)) begin
			w_eff = LEF_DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = LEF_DIM_W'(image_width);
		end
		if (image_height < LEF_DIM_W'(LEF_MIN_DIM)) begin
			h_eff = LEF_DIM_W'(LEF_MIN_DIM);
		end else if (image_height > LEF_DIM_W'(LEF_MAX_HEIGHT)) begin
			h_eff = LEF_DIM_W'(LEF_MAX_HEIGHT);
		end else begin
			h_eff = image_height;
		end
	end

	// classify the position and step the raster counters
	always_comb begin
		c_ext = LEF_DIM_W'(col_q);
		r_ext = LEF_DIM_W'(row_q);
		c_inc = c_ext + LEF_DIM_W'(1);
		r_inc = r_ext + LEF_DIM_W'(1);
		emit  = (c_ext >= LEF_DIM_W'(LEF_FIRST_IN)) && (r_ext >= LEF_DIM_W'(LEF_FIRST_IN))
			&& (c_ext < w_eff) && (r_ext < h_eff);
		last  = (c_ext == w_eff - LEF_DIM_W'(1)) && (r_ext == h_eff - LEF_DIM_W'(1));
		if (c_inc >= w_eff) begin
			col_n = '0;
			row_n = (r_inc >= h_eff) ? '0 : LEF_ROW_W'(r_inc);
		end else begin
			col_n = COL_W'(c_inc);
			row_n = (r_ext >= h_eff) ? '0 : row_q;
		end
	end

	// the whole front moves together; it halts only while its sum waits on a full queue
	assign adv       = !valid_s2 || !q_stat.full;
	assign pix.ready = adv;
	assign accept    = pix.valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else begin
			if (accept) begin
				col_q <= col_n;
				row_q <= row_n;
			end
			if (adv) begin
				valid_s1 <= accept;
				valid_s2 <= valid_s1 && emit_s1;
				if (valid_s1) begin
					for (int k = 0; k < 3; k++) begin
						win_q[3*k]   <= win_q[3*k+1];
						win_q[3*k+1] <= win_q[3*k+2];
					end
					win_q[2] <= rd_q[LEF_PIX_W-1:0];
					win_q[5] <= rd_q[MEM_W-1:LEF_PIX_W];
					win_q[8] <= pix_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pix.pixel_in;
			addr_s1 <= col_q;
			emit_s1 <= emit;
			col_s1  <= col_q - COL_W'(1);
			row_s1  <= row_q - LEF_ROW_W'(1);
			last_s1 <= last;
		end
		if (adv && valid_s1) begin
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			last_s2 <= last_s1;
		end
	end

	// read-before-write per column; consecutive pixels never share a column
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[col_q];
		end
		if (adv && valid_s1) begin
			line_mem[addr_s1] <= {pix_s1, rd_q[MEM_W-1:LEF_PIX_W]};
		end
	end

	assign sum    = lef_kernel_sum(win_q, kernel_select);
	assign q_push = valid_s2 && !q_stat.full;
	assign q_data = {sum, col_s2, row_s2, last_s2};

endmodule

`default_nettype wire

// ----- rtl/lef_back.sv -----
// ----------------------------------------------------------------------------
// lef_back: gain multiply, truncation, saturation and result register
// Pops queued kernel sums and drives the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_back import lef_pkg::*; #(
	parameter int unsigned COL_W  = $clog2(LEF_MAX_WIDTH),
	parameter int unsigned DATA_W = LEF_SUM_W + COL_W + LEF_ROW_W + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [LEF_GAIN_W-1:0] gain,
	input  wire lef_q_stat_t           q_stat,
	input  wire logic [DATA_W-1:0]     q_data,
	output logic                       q_pop,
	lef_res_if.source                  res
);

	logic signed [LEF_SUM_W-1:0] q_sum;
	logic [LEF_SUM_W-1:0]        mag;
	logic                        out_free;
	logic                        adv_s1;

	logic                        valid_s1;
	logic [LEF_PROD_W-1:0]       prod_s1;
	logic [COL_W-1:0]            col_s1;
	logic [LEF_ROW_W-1:0]        row_s1;
	logic                        last_s1;

	logic                        res_valid_q;
	logic [LEF_PIX_W-1:0]        edge_q;
	logic [COL_W-1:0]            col_q;
	logic [LEF_ROW_W-1:0]        row_q;
	logic                        last_q;

	assign q_sum = q_data[DATA_W-1 -: LEF_SUM_W];
	assign mag   = q_sum[LEF_SUM_W-1] ? LEF_SUM_W'(-q_sum) : LEF_SUM_W'(q_sum);

	assign out_free = !res_valid_q || res.ready;
	assign adv_s1   = !valid_s1 || out_free;
	assign q_pop    = q_stat.nonempty && adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= q_stat.nonempty;
			end
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s1 <= LEF_PROD_W'(mag) * LEF_PROD_W'(gain);
			col_s1  <= q_data[LEF_ROW_W+1 +: COL_W];
			row_s1  <= q_data[1 +: LEF_ROW_W];
			last_s1 <= q_data[0];
		end
		if (out_free && valid_s1) begin
			// drop the 8 fraction bits, clip at full scale
			edge_q <= (prod_s1[LEF_PROD_W-1:LEF_FRAC_W+LEF_PIX_W] != '0)
				? LEF_PIX_W'(LEF_SAT_MAX) : prod_s1[LEF_FRAC_W +: LEF_PIX_W];
			col_q  <= col_s1;
			row_q  <= row_s1;
			last_q <= last_s1;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.edge_value = edge_q;
	assign res.out_column = col_q;
	assign res.out_row    = row_q;
	assign res.frame_last = last_q;

endmodule

`default_nettype wire

// ----- rtl/laplacian_edge_filter_3x3_unit.sv -----
// ----------------------------------------------------------------------------
// laplacian_edge_filter_3x3_unit: 3x3 Laplacian edge filter, top level
//
// Channels: pix takes 8-bit grayscale pixels in raster order, one per
// transfer. res gives one result per interior pixel: the saturated edge
// magnitude, its column and row and a frame-last flag. Border pixels give
// no result. cfg writes kernel_select, gain, image_width, image_height by
// index and is always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. Throughput: one pixel per
// clock while res takes every result, the line store being a single read and
// single write port used once per pixel. Path: after its pixel's transfer a
// result passes the line store read, window, queue, multiply, result register.
// Stall: the result register holds until taken; the multiplier stage and a
// 4-entry queue absorb further results, then pix.ready drops.
// Reset: registers go to defaults (four-neighbour, gain 2.0, 256x256),
// counters and window clear, pipeline empties. Line store contents are not
// cleared; the first two rows of each frame rewrite them before any use.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_edge_filter_3x3_unit import lef_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	lef_pix_if.sink   pix,
	lef_res_if.source res,
	lef_cfg_if.sink   cfg
);

	// line store depth and column width follow the result channel's column field
	localparam int unsigned MAX_WIDTH = LEF_MAX_WIDTH;
	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned DATA_W = LEF_SUM_W + COL_W + LEF_ROW_W + 1;

	// configuration registers
	logic [LEF_KSEL_W-1:0]  kernel_select_q;
	logic [LEF_GAIN_W-1:0]  gain_q;
	logic [LEF_IMG_W_W-1:0] image_width_q;
	logic [LEF_IMG_H_W-1:0] image_height_q;

	// front to queue to back
	logic              q_push;
	logic              q_pop;
	logic [DATA_W-1:0] q_push_data;
	logic [DATA_W-1:0] q_pop_data;
	lef_q_stat_t       q_stat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_select_q <= LEF_KSEL_RST;
			gain_q          <= LEF_GAIN_RST;
			image_width_q   <= LEF_WIDTH_RST;
			image_height_q  <= LEF_HEIGHT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				LEF_REG_KERNEL: kernel_select_q <= cfg.data[LEF_KSEL_W-1:0];
				LEF_REG_GAIN:   gain_q          <= cfg.data[LEF_GAIN_W-1:0];
				LEF_REG_WIDTH:  image_width_q   <= cfg.data[LEF_IMG_W_W-1:0];
				LEF_REG_HEIGHT: image_height_q  <= cfg.data[LEF_IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	// front: counters, line store, window, kernel sum
	lef_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W),
		.DATA_W    (DATA_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pix           (pix),
		.kernel_select (kernel_select_q),
		.image_width   (image_width_q),
		.image_height  (image_height_q),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_data        (q_push_data)
	);

	// decoupling queue
	lef_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.stat      (q_stat),
		.pop_data  (q_pop_data)
	);

	// back: gain, saturation, result register
	lef_back #(
		.COL_W  (COL_W),
		.DATA_W (DATA_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.gain   (gain_q),
		.q_stat (q_stat),
		.q_data (q_pop_data),
		.q_pop  (q_pop),
		.res    (res)
	);

`ifndef SYNTH
	// the front must never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue push while full");

	// the back must never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.nonempty)
		else $error("queue pop while empty");

	// a full queue with no pop stays full on the next cycle
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !q_pop) |=> q_stat.full)
		else $error("full queue lost an entry without a pop");
`endif

endmodule

`default_nettype wire
